// ----- sv/tfmmr_pkg.sv -----
// Package for the track mean-frequency / RMS-magnitude statistics block.
// Holds field widths, the 1/(2*pi) scale constant and the sequencer state type.
// No dependencies; used by sv/track_freq_mean_mag_rms.sv.
package tfmmr_pkg;

    // Field widths of the input and result words.
    localparam int FRAME_W = 19;
    localparam int OMEGA_W = 24;
    localparam int MAG_W   = 16;

    // Default depth limit of one track.
    localparam int MAX_TRACK_POINTS_DEF = 4096;

    // 1/(2*pi) in Q16, and the fraction shift that goes with it.
    localparam int INV_W = 14;
    localparam logic [INV_W-1:0] INV_TWO_PI_Q16 = 14'd10430;
    localparam int FRAC_SHIFT = 16;

    // Square root: a 32-bit radicand gives a 16-bit root, two radicand bits per step.
    localparam int RAD_W = 2 * MAG_W;
    localparam int ROOT_W = MAG_W;
    localparam int ROOT_REM_W = MAG_W + 3;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ACC  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIVF = 7'b0001000,
        ST_DIVS = 7'b0010000,
        ST_ROOT = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

endpackage

// ----- sv/track_freq_mean_mag_rms.sv -----
// Top level of the track statistics block: per-track sums, frame extents, and
// an end-of-track sequence of divide and square root on one shared subtractor.
// Depends on sv/tfmmr_pkg.sv.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid, in_stall  | frame_number, omega_word, magnitude,
//          |           |                     | last_of_track, last_of_set
//  out     | output    | out_valid, out_stall| mean_frequency, rms_magnitude,
//          |           |                     | track_first_frame, track_last_frame,
//          |           |                     | set_first_frame, set_last_frame
//
// A point that does not end its track goes through the accept in ST_IDLE and one
// multiply-accumulate state, ST_ACC. A point that ends its track then passes through
// ST_MUL, the bit-serial divides of the mean and of the mean square and the 16-step
// square root, all on one subtractor, before ST_FIN hands over the result.
// rst_n clears the sums, the count and the extents at once; no clearing pass follows.
// A result waits in the output register while out_stall is high; the next points are
// still taken, and only a second result waits for the first to be taken.
module track_freq_mean_mag_rms #(
    parameter int MAX_TRACK_POINTS = tfmmr_pkg::MAX_TRACK_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tfmmr_pkg::FRAME_W-1:0] frame_number,
    input  logic [tfmmr_pkg::OMEGA_W-1:0] omega_word,
    input  logic [tfmmr_pkg::MAG_W-1:0]   magnitude,
    input  logic                          last_of_track,
    input  logic                          last_of_set,
    // Result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tfmmr_pkg::OMEGA_W-1:0] mean_frequency,
    output logic [tfmmr_pkg::MAG_W-1:0]   rms_magnitude,
    output logic [tfmmr_pkg::FRAME_W-1:0] track_first_frame,
    output logic [tfmmr_pkg::FRAME_W-1:0] track_last_frame,
    output logic [tfmmr_pkg::FRAME_W-1:0] set_first_frame,
    output logic [tfmmr_pkg::FRAME_W-1:0] set_last_frame
);

    // Derived widths.
    localparam int FRAME_W = tfmmr_pkg::FRAME_W;
    localparam int OMEGA_W = tfmmr_pkg::OMEGA_W;
    localparam int MAG_W   = tfmmr_pkg::MAG_W;
    localparam int CNT_W   = $clog2(MAX_TRACK_POINTS + 1);
    localparam int FREQ_W  = OMEGA_W + CNT_W;
    localparam int SQ_W    = 2 * MAG_W + CNT_W;
    localparam int PROD_W  = FREQ_W + MAG_W;
    localparam int NUM_W   = FREQ_W + tfmmr_pkg::INV_W;
    localparam int DF_W    = NUM_W + 1 - tfmmr_pkg::FRAC_SHIFT;
    localparam int DV_W    = (DF_W > SQ_W) ? DF_W : SQ_W;
    localparam int SUB_W   = (CNT_W + 1 > tfmmr_pkg::ROOT_REM_W) ?
                             CNT_W + 1 : tfmmr_pkg::ROOT_REM_W;
    localparam int STEP_W  = $clog2(DV_W + 1);
    localparam int RAD_W   = tfmmr_pkg::RAD_W;
    localparam int ROOT_W  = tfmmr_pkg::ROOT_W;

    // Control and state registers.
    tfmmr_pkg::state_t   state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]   freq_sum_reg, freq_sum_next;
    logic [SQ_W-1:0]     square_sum_reg, square_sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                trk_seen_reg, trk_seen_next;
    logic [FRAME_W-1:0]  trk_min_reg, trk_min_next;
    logic [FRAME_W-1:0]  trk_max_reg, trk_max_next;
    logic                set_seen_reg, set_seen_next;
    logic [FRAME_W-1:0]  set_min_reg, set_min_next;
    logic [FRAME_W-1:0]  set_max_reg, set_max_next;

    // Datapath registers.
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [OMEGA_W-1:0]  omega_reg, omega_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                end_track_reg, end_track_next;
    logic                end_set_reg, end_set_next;
    logic [DV_W-1:0]     dvd_reg, dvd_next;
    logic [SUB_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;
    logic [OMEGA_W-1:0]  mean_reg, mean_next;
    logic [OMEGA_W-1:0]  out_mean_reg, out_mean_next;
    logic [MAG_W-1:0]    out_rms_reg, out_rms_next;
    logic [FRAME_W-1:0]  out_tfirst_reg, out_tfirst_next;
    logic [FRAME_W-1:0]  out_tlast_reg, out_tlast_next;
    logic [FRAME_W-1:0]  out_sfirst_reg, out_sfirst_next;
    logic [FRAME_W-1:0]  out_slast_reg, out_slast_next;

    // Shared multiplier and shared subtractor.
    logic [FREQ_W-1:0]   mul_a;
    logic [MAG_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;
    logic [SUB_W-1:0]    sub_a;
    logic [SUB_W-1:0]    sub_b;
    logic [SUB_W:0]      sub_full;
    logic                sub_ge;

    // Helper values.
    logic                in_accept;
    logic                out_take;
    logic                out_free;
    logic [FREQ_W-1:0]   abs_sum;
    logic [NUM_W:0]      num_round;
    logic [DV_W-1:0]     div_shift;
    logic [FRAME_W-1:0]  set_min_new;
    logic [FRAME_W-1:0]  set_max_new;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Magnitude of the frequency sum for the scaled mean.
    assign abs_sum = freq_sum_reg[FREQ_W-1] ? (~freq_sum_reg + 1'b1) : freq_sum_reg;

    // The multiplier squares the magnitude while accumulating, and scales the sum by
    // 1/(2*pi) at the start of the end-of-track sequence.
    always_comb
    begin
        if (state_reg == tfmmr_pkg::ST_MUL)
        begin
            mul_a = abs_sum;
            mul_b = MAG_W'(tfmmr_pkg::INV_TWO_PI_Q16);
        end
        else
        begin
            mul_a = FREQ_W'(mag_reg);
            mul_b = mag_reg;
        end
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Add half the divisor for rounding; dividing by count << 16 equals dropping
    // the 16 fraction bits and dividing by count.
    assign num_round = {1'b0, prod[NUM_W-1:0]}
                     + ((NUM_W + 1)'(count_reg) << (tfmmr_pkg::FRAC_SHIFT - 1));

    // Shared subtractor: a restoring divide step or a square root step.
    always_comb
    begin
        if (state_reg == tfmmr_pkg::ST_ROOT)
        begin
            sub_a = {rem_reg[SUB_W-3:0], dvd_reg[DV_W-1 -: 2]};
            sub_b = SUB_W'({root_reg, 2'b01});
        end
        else
        begin
            sub_a = {rem_reg[SUB_W-2:0], dvd_reg[DV_W-1]};
            sub_b = SUB_W'(count_reg);
        end
    end
    assign sub_full  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge    = !sub_full[SUB_W];
    assign div_shift = {dvd_reg[DV_W-2:0], sub_ge};

    // Set extent including the track that just ended.
    assign set_min_new = (!set_seen_reg || trk_min_reg < set_min_reg) ? trk_min_reg : set_min_reg;
    assign set_max_new = (!set_seen_reg || trk_max_reg > set_max_reg) ? trk_max_reg : set_max_reg;

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        freq_sum_next   = freq_sum_reg;
        square_sum_next = square_sum_reg;
        count_next      = count_reg;
        trk_seen_next   = trk_seen_reg;
        trk_min_next    = trk_min_reg;
        trk_max_next    = trk_max_reg;
        set_seen_next   = set_seen_reg;
        set_min_next    = set_min_reg;
        set_max_next    = set_max_reg;
        frame_next      = frame_reg;
        omega_next      = omega_reg;
        mag_next        = mag_reg;
        end_track_next  = end_track_reg;
        end_set_next    = end_set_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        mean_next       = mean_reg;
        out_mean_next   = out_mean_reg;
        out_rms_next    = out_rms_reg;
        out_tfirst_next = out_tfirst_reg;
        out_tlast_next  = out_tlast_reg;
        out_sfirst_next = out_sfirst_reg;
        out_slast_next  = out_slast_reg;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tfmmr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    frame_next     = frame_number;
                    omega_next     = omega_word;
                    mag_next       = magnitude;
                    end_track_next = last_of_track;
                    end_set_next   = last_of_set;
                    state_next     = tfmmr_pkg::ST_ACC;
                end
            end

            tfmmr_pkg::ST_ACC:
            begin
                // Frame extent of the track.
                trk_seen_next = 1'b1;
                if (!trk_seen_reg || frame_reg < trk_min_reg)
                begin
                    trk_min_next = frame_reg;
                end
                if (!trk_seen_reg || frame_reg > trk_max_reg)
                begin
                    trk_max_next = frame_reg;
                end
                // Sums stop growing once the track is full.
                if (count_reg < CNT_W'(MAX_TRACK_POINTS))
                begin
                    freq_sum_next = freq_sum_reg
                                  + {{(FREQ_W - OMEGA_W){omega_reg[OMEGA_W-1]}}, omega_reg};
                    square_sum_next = square_sum_reg + SQ_W'(prod[2*MAG_W-1:0]);
                    count_next = count_reg + 1'b1;
                end
                state_next = end_track_reg ? tfmmr_pkg::ST_MUL : tfmmr_pkg::ST_IDLE;
            end

            tfmmr_pkg::ST_MUL:
            begin
                // Load the rounded, scaled frequency sum into the divider.
                neg_next   = freq_sum_reg[FREQ_W-1];
                dvd_next   = DV_W'(num_round[NUM_W:tfmmr_pkg::FRAC_SHIFT]) << (DV_W - DF_W);
                rem_next   = '0;
                step_next  = STEP_W'(DF_W - 1);
                state_next = tfmmr_pkg::ST_DIVF;
            end

            tfmmr_pkg::ST_DIVF:
            begin
                rem_next = sub_ge ? sub_full[SUB_W-1:0] : sub_a;
                dvd_next = div_shift;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // Quotient done: sign the mean and start the mean square.
                    mean_next  = neg_reg ? (~div_shift[OMEGA_W-1:0] + 1'b1)
                                         : div_shift[OMEGA_W-1:0];
                    dvd_next   = DV_W'(square_sum_reg) << (DV_W - SQ_W);
                    rem_next   = '0;
                    step_next  = STEP_W'(SQ_W - 1);
                    state_next = tfmmr_pkg::ST_DIVS;
                end
            end

            tfmmr_pkg::ST_DIVS:
            begin
                rem_next = sub_ge ? sub_full[SUB_W-1:0] : sub_a;
                dvd_next = div_shift;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // Mean square fits 32 bits; align it for the root.
                    dvd_next   = DV_W'(div_shift[RAD_W-1:0]) << (DV_W - RAD_W);
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    state_next = tfmmr_pkg::ST_ROOT;
                end
            end

            tfmmr_pkg::ST_ROOT:
            begin
                rem_next  = sub_ge ? sub_full[SUB_W-1:0] : sub_a;
                dvd_next  = dvd_reg << 2;
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = tfmmr_pkg::ST_FIN;
                end
            end

            tfmmr_pkg::ST_FIN:
            begin
                // Hand the result over once the output register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_mean_next   = mean_reg;
                    out_rms_next    = root_reg;
                    out_tfirst_next = trk_min_reg;
                    out_tlast_next  = trk_max_reg;
                    out_sfirst_next = set_min_new;
                    out_slast_next  = set_max_new;
                    set_min_next    = set_min_new;
                    set_max_next    = set_max_new;
                    set_seen_next   = !end_set_reg;
                    freq_sum_next   = '0;
                    square_sum_next = '0;
                    count_next      = '0;
                    trk_seen_next   = 1'b0;
                    state_next      = tfmmr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tfmmr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and accumulator registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tfmmr_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            freq_sum_reg   <= '0;
            square_sum_reg <= '0;
            count_reg      <= '0;
            trk_seen_reg   <= 1'b0;
            trk_min_reg    <= '0;
            trk_max_reg    <= '0;
            set_seen_reg   <= 1'b0;
            set_min_reg    <= '0;
            set_max_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            freq_sum_reg   <= freq_sum_next;
            square_sum_reg <= square_sum_next;
            count_reg      <= count_next;
            trk_seen_reg   <= trk_seen_next;
            trk_min_reg    <= trk_min_next;
            trk_max_reg    <= trk_max_next;
            set_seen_reg   <= set_seen_next;
            set_min_reg    <= set_min_next;
            set_max_reg    <= set_max_next;
        end
    end

    // Payload and iteration registers.
    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        omega_reg      <= omega_next;
        mag_reg        <= mag_next;
        end_track_reg  <= end_track_next;
        end_set_reg    <= end_set_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        step_reg       <= step_next;
        neg_reg        <= neg_next;
        mean_reg       <= mean_next;
        out_mean_reg   <= out_mean_next;
        out_rms_reg    <= out_rms_next;
        out_tfirst_reg <= out_tfirst_next;
        out_tlast_reg  <= out_tlast_next;
        out_sfirst_reg <= out_sfirst_next;
        out_slast_reg  <= out_slast_next;
    end

    // Ports.
    assign in_stall          = (state_reg != tfmmr_pkg::ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign mean_frequency    = out_mean_reg;
    assign rms_magnitude     = out_rms_reg;
    assign track_first_frame = out_tfirst_reg;
    assign track_last_frame  = out_tlast_reg;
    assign set_first_frame   = out_sfirst_reg;
    assign set_last_frame    = out_slast_reg;

    // A new result word appears only out of the hand-over state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == tfmmr_pkg::ST_FIN))
        else $error("result word raised outside the hand-over state");

    // An accepted word is always followed by its accumulate cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == tfmmr_pkg::ST_ACC)
        else $error("accepted word not accumulated");

    // The point count never passes the track depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TRACK_POINTS))
        else $error("point count beyond track depth");

    // During a divide the partial remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfmmr_pkg::ST_DIVF || state_reg == tfmmr_pkg::ST_DIVS)
        |-> rem_reg < SUB_W'(count_reg))
        else $error("divider remainder not below divisor");

endmodule

// ----- sim/track_freq_mean_mag_rms_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the track mean-frequency / RMS-magnitude statistics block.
// Sends directed points, then random bursts, under random output stalls; checks each result.
// Depends on sv/tfmmr_pkg.sv and sv/track_freq_mean_mag_rms.sv.
module track_freq_mean_mag_rms_tb;

    localparam int FRAME_W = tfmmr_pkg::FRAME_W;
    localparam int OMEGA_W = tfmmr_pkg::OMEGA_W;
    localparam int MAG_W   = tfmmr_pkg::MAG_W;
    localparam int ROOT_W  = tfmmr_pkg::ROOT_W;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_POINTS = 1200;

    // One input word: a track point.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [OMEGA_W-1:0] omega;
        logic [MAG_W-1:0]   mag;
        logic               end_track;
        logic               end_set;
    } track_point_t;

    // One result word: the statistics of a finished track.
    typedef struct packed {
        logic [OMEGA_W-1:0] mean_freq;
        logic [MAG_W-1:0]   rms_mag;
        logic [FRAME_W-1:0] trk_first;
        logic [FRAME_W-1:0] trk_last;
        logic [FRAME_W-1:0] set_first;
        logic [FRAME_W-1:0] set_last;
    } track_stats_t;

    // Running track and set statistics, and the results still owed by the block.
    class track_stats_tracker;
        longint            freq_acc;
        longint unsigned   square_acc;
        int unsigned       point_total;
        bit [FRAME_W-1:0]  trk_lo, trk_hi, set_lo, set_hi;
        bit                trk_open, set_open;
        track_stats_t      pending_stats[$];
        int                mismatch_count;
        int                results_seen;

        // Floor square root, one result bit per step from the top.
        function bit [ROOT_W-1:0] int_sqrt(bit [31:0] v);
            bit [ROOT_W-1:0] r;
            bit [ROOT_W-1:0] t;
            r = '0;
            for (int b = ROOT_W - 1; b >= 0; b--)
            begin
                t = r | (ROOT_W'(1) << b);
                if (longint'(t) * longint'(t) <= longint'(v))
                    r = t;
            end
            return r;
        endfunction

        // Fold one accepted point into the sums; a track end yields one expected result.
        function void note_point(track_point_t p);
            track_stats_t    st;
            bit              neg;
            longint unsigned abs_sum, num, den, q, mean_sq;
            if (!trk_open)
            begin
                trk_lo = p.frame;
                trk_hi = p.frame;
                trk_open = 1'b1;
            end
            else
            begin
                if (p.frame < trk_lo) trk_lo = p.frame;
                if (p.frame > trk_hi) trk_hi = p.frame;
            end
            // Past the point limit only the frame extent moves.
            if (point_total < tfmmr_pkg::MAX_TRACK_POINTS_DEF)
            begin
                freq_acc += longint'($signed(p.omega));
                square_acc += longint'(p.mag) * longint'(p.mag);
                point_total++;
            end
            if (!p.end_track)
                return;

            // Mean scaled by 1/(2*pi), rounded once, half away from zero.
            neg = (freq_acc < 0);
            abs_sum = neg ? -freq_acc : freq_acc;
            num = abs_sum * tfmmr_pkg::INV_TWO_PI_Q16;
            den = longint'(point_total) << tfmmr_pkg::FRAC_SHIFT;
            q = (num + den / 2) / den;
            if (neg)
                q = -q;
            mean_sq = square_acc / point_total;

            if (!set_open)
            begin
                set_lo = trk_lo;
                set_hi = trk_hi;
                set_open = 1'b1;
            end
            else
            begin
                if (trk_lo < set_lo) set_lo = trk_lo;
                if (trk_hi > set_hi) set_hi = trk_hi;
            end

            st.mean_freq = q[OMEGA_W-1:0];
            st.rms_mag   = int_sqrt(mean_sq[31:0]);
            st.trk_first = trk_lo;
            st.trk_last  = trk_hi;
            st.set_first = set_lo;
            st.set_last  = set_hi;
            pending_stats.push_back(st);

            freq_acc = 0;
            square_acc = 0;
            point_total = 0;
            trk_open = 1'b0;
            if (p.end_set)
                set_open = 1'b0;
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            mismatch_count++;
            $display("%0t ns: result %0d, %s is 0x%0h, expected 0x%0h",
                     $time, results_seen, field, got, want);
        endtask

        // Compare a result word with the oldest expected one, field by field.
        task check_stats(track_stats_t got);
            track_stats_t want;
            results_seen++;
            if (pending_stats.size() == 0)
            begin
                report_mismatch("unexpected result, mean_frequency", got.mean_freq, 0);
                return;
            end
            want = pending_stats.pop_front();
            if (got.mean_freq !== want.mean_freq)
                report_mismatch("mean_frequency", got.mean_freq, want.mean_freq);
            if (got.rms_mag !== want.rms_mag)
                report_mismatch("rms_magnitude", got.rms_mag, want.rms_mag);
            if (got.trk_first !== want.trk_first)
                report_mismatch("track_first_frame", got.trk_first, want.trk_first);
            if (got.trk_last !== want.trk_last)
                report_mismatch("track_last_frame", got.trk_last, want.trk_last);
            if (got.set_first !== want.set_first)
                report_mismatch("set_first_frame", got.set_first, want.set_first);
            if (got.set_last !== want.set_last)
                report_mismatch("set_last_frame", got.set_last, want.set_last);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [FRAME_W-1:0] frame_number;
    logic [OMEGA_W-1:0] omega_word;
    logic [MAG_W-1:0]   magnitude;
    logic               last_of_track;
    logic               last_of_set;
    logic               out_valid;
    logic               out_stall;
    logic [OMEGA_W-1:0] mean_frequency;
    logic [MAG_W-1:0]   rms_magnitude;
    logic [FRAME_W-1:0] track_first_frame;
    logic [FRAME_W-1:0] track_last_frame;
    logic [FRAME_W-1:0] set_first_frame;
    logic [FRAME_W-1:0] set_last_frame;

    track_stats_tracker board = new();
    track_stats_t       seen_stats;
    int                 points_sent;
    int                 tracks_sent;
    int                 burst_left;
    int                 steady_left;
    int                 idle_count;
    bit                 hold_off_req;

    track_freq_mean_mag_rms u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .frame_number      (frame_number),
        .omega_word        (omega_word),
        .magnitude         (magnitude),
        .last_of_track     (last_of_track),
        .last_of_set       (last_of_set),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .mean_frequency    (mean_frequency),
        .rms_magnitude     (rms_magnitude),
        .track_first_frame (track_first_frame),
        .track_last_frame  (track_last_frame),
        .set_first_frame   (set_first_frame),
        .set_last_frame    (set_last_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic track_point_t make_point(int unsigned f, int o, int unsigned m,
                                                bit lt, bit ls);
        track_point_t p;
        p.frame     = FRAME_W'(f);
        p.omega     = OMEGA_W'(o);
        p.mag       = MAG_W'(m);
        p.end_track = lt;
        p.end_set   = ls;
        return p;
    endfunction

    // Offer one word from the falling edge and hold it until it is taken.
    task send_point(track_point_t p);
        @(negedge clk);
        in_valid      <= 1'b1;
        frame_number  <= p.frame;
        omega_word    <= p.omega;
        magnitude     <= p.mag;
        last_of_track <= p.end_track;
        last_of_set   <= p.end_set;
        do
            @(posedge clk);
        while (in_stall);
        board.note_point(p);
        points_sent++;
        if (p.end_track)
            tracks_sent++;
    endtask

    task idle_for(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Bursts of random length with random gaps, and now and then a long gap-free stretch.
    task pace();
        if (steady_left > 0)
            steady_left--;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            idle_for($urandom_range(1, 12));
            burst_left = $urandom_range(0, 25);
            if ($urandom_range(0, 7) == 0)
                steady_left = $urandom_range(50, 150);
        end
    endtask

    task wait_drained();
        idle_for(1);
        while (board.pending_stats.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: reset, directed cases, then random tracks.
    initial
    begin
        track_point_t     p;
        int               track_len;
        int               rand_start;
        bit               set_end;
        bit               pause_done;
        bit [FRAME_W-1:0] base;

        rst_n = 1'b0;
        in_valid = 1'b0;
        frame_number = '0;
        omega_word = '0;
        magnitude = '0;
        last_of_track = 1'b0;
        last_of_set = 1'b0;
        hold_off_req = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single-point tracks at the field extremes.
        send_point(make_point(0, 0, 0, 1, 0));
        send_point(make_point(524287, 8388607, 65535, 1, 0));
        send_point(make_point(299999, -8388608, 65535, 1, 1));
        // A set mark without a track mark is ignored.
        send_point(make_point(100, -1, 1, 0, 1));
        send_point(make_point(50, 1, 2, 0, 0));
        send_point(make_point(200, 128, 3, 1, 0));
        // Frames beyond 299999 compare like any other value.
        send_point(make_point(400000, 1608, 300, 0, 0));
        send_point(make_point(300000, -1608, 301, 0, 0));
        send_point(make_point(524287, 1609, 302, 1, 0));
        // Small means on both sides of the rounding point.
        send_point(make_point(10, 3, 5, 1, 0));
        send_point(make_point(11, -3, 5, 1, 0));
        send_point(make_point(12, 4, 6, 1, 0));
        send_point(make_point(13, -4, 6, 1, 1));
        // Extremes that cancel to a sum of minus one.
        send_point(make_point(7, 8388607, 65535, 0, 0));
        send_point(make_point(3, -8388608, 0, 1, 1));
        wait_drained();

        // Random tracks, mostly short, some long.
        rand_start = points_sent;
        pause_done = 1'b0;
        while (points_sent < rand_start + RANDOM_POINTS)
        begin
            track_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                    : $urandom_range(1, 8);
            set_end = ($urandom_range(0, 3) == 0);
            base = FRAME_W'($urandom_range(0, 299000));
            for (int i = 0; i < track_len; i++)
            begin
                case ($urandom_range(0, 9))
                    0: p.frame = FRAME_W'($urandom_range(0, 524287));
                    1: p.frame = $urandom_range(0, 1) ? '1 : '0;
                    default: p.frame = base + FRAME_W'($urandom_range(0, 40));
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: p.omega = OMEGA_W'($urandom);
                    5: p.omega = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                    default: p.omega = OMEGA_W'($urandom_range(0, 4000)) - 24'd2000;
                endcase
                case ($urandom_range(0, 9))
                    0: p.mag = $urandom_range(0, 1) ? '1 : '0;
                    default: p.mag = MAG_W'($urandom);
                endcase
                p.end_track = (i == track_len - 1);
                p.end_set = p.end_track ? set_end : ($urandom_range(0, 9) == 0);
                send_point(p);
                pace();
                // The receiver holds off while points keep coming in.
                if (points_sent == rand_start + 400)
                    hold_off_req = 1'b1;
            end
            if (!pause_done && points_sent >= rand_start + 800)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d track points in %0d tracks; %0d results compared.",
                 points_sent, tracks_sent, board.results_seen);
        $display("Covered field extremes, ignored set marks, bursts, a long hold and stalls.");
        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: stall patterns that change from segment to segment, plus one long hold.
    initial
    begin
        int seg;
        int mode;
        int period;
        out_stall = 1'b0;
        forever
        begin
            seg = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            period = $urandom_range(2, 6);
            for (int c = 0; c < seg; c++)
            begin
                @(negedge clk);
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1)
                    begin
                        @(negedge clk);
                        out_stall <= 1'b1;
                    end
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 9) < 3);
                        2: out_stall <= ($urandom_range(0, 9) < 8);
                        default: out_stall <= (c % period == 0);
                    endcase
                end
            end
        end
    end

    // Each result word taken by the receiver is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_stats.mean_freq = mean_frequency;
            seen_stats.rms_mag   = rms_magnitude;
            seen_stats.trk_first = track_first_frame;
            seen_stats.trk_last  = track_last_frame;
            seen_stats.set_first = set_first_frame;
            seen_stats.set_last  = set_last_frame;
            board.check_stats(seen_stats);
        end
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == IDLE_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles, %0d results pending.",
                     IDLE_LIMIT, board.pending_stats.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
